// ===== src/tape_image_block_scanner_core_defines.svh =====
// assertion macros for the tape image block scanner checker
// depends on clk and rst being visible where the macros are used
`ifndef TAPE_IMAGE_BLOCK_SCANNER_CORE_DEFINES_SVH
`define TAPE_IMAGE_BLOCK_SCANNER_CORE_DEFINES_SVH

// check while out of reset
`define TISC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tisc check failed");

// check that also covers the reset cycles
`define TISC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tisc reset check failed");

`endif

// ===== src/tisc_pkg.sv =====
// shared types, constants and the block id rule table for the tape image scanner
// no dependencies
package tisc_pkg;

  localparam int POS_BITS    = 32;
  localparam int CNT_BITS    = 16;
  localparam int SCAN_MARGIN = 10;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_ID   = 3'b001,
    PH_HDR  = 3'b010,
    PH_SKIP = 3'b100
  } phase_t;

  typedef struct packed {
    logic       known;
    logic [4:0] off;
    logic [2:0] width;
    logic [1:0] mult;
    logic [4:0] add;
  } rule_t;

  typedef struct packed {
    logic [POS_BITS-1:0] offset;
    logic [7:0]          id;
    logic [33:0]         prod;
    logic [4:0]          add;
    logic                known;
  } evt_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  function automatic rule_t lookup_rule(input logic [7:0] id);
    rule_t r;
    case (id)
      8'h10: r = '{1'b1, 5'h02, 3'd2, 2'd1, 5'h04};
      8'h11: r = '{1'b1, 5'h0F, 3'd3, 2'd1, 5'h12};
      8'h12: r = '{1'b1, 5'h00, 3'd0, 2'd1, 5'h04};
      8'h13: r = '{1'b1, 5'h00, 3'd1, 2'd2, 5'h01};
      8'h14: r = '{1'b1, 5'h07, 3'd3, 2'd1, 5'h0A};
      8'h15: r = '{1'b1, 5'h05, 3'd3, 2'd1, 5'h08};
      8'h16: r = '{1'b1, 5'h00, 3'd4, 2'd1, 5'h04};
      8'h17: r = '{1'b1, 5'h00, 3'd4, 2'd1, 5'h04};
      8'h20: r = '{1'b1, 5'h00, 3'd0, 2'd1, 5'h02};
      8'h21: r = '{1'b1, 5'h00, 3'd1, 2'd1, 5'h01};
      8'h22: r = '{1'b1, 5'h00, 3'd0, 2'd1, 5'h00};
      8'h23: r = '{1'b1, 5'h00, 3'd0, 2'd1, 5'h02};
      8'h24: r = '{1'b1, 5'h00, 3'd0, 2'd1, 5'h02};
      8'h25: r = '{1'b1, 5'h00, 3'd0, 2'd1, 5'h00};
      8'h26: r = '{1'b1, 5'h00, 3'd2, 2'd2, 5'h02};
      8'h27: r = '{1'b1, 5'h00, 3'd0, 2'd1, 5'h00};
      8'h28: r = '{1'b1, 5'h00, 3'd2, 2'd1, 5'h02};
      8'h2A: r = '{1'b1, 5'h00, 3'd0, 2'd1, 5'h04};
      8'h30: r = '{1'b1, 5'h00, 3'd1, 2'd1, 5'h01};
      8'h31: r = '{1'b1, 5'h01, 3'd1, 2'd1, 5'h02};
      8'h32: r = '{1'b1, 5'h00, 3'd2, 2'd1, 5'h02};
      8'h33: r = '{1'b1, 5'h00, 3'd1, 2'd3, 5'h01};
      8'h34: r = '{1'b1, 5'h00, 3'd0, 2'd1, 5'h08};
      8'h35: r = '{1'b1, 5'h10, 3'd4, 2'd1, 5'h14};
      8'h40: r = '{1'b1, 5'h01, 3'd3, 2'd1, 5'h04};
      8'h5A: r = '{1'b1, 5'h00, 3'd0, 2'd1, 5'h09};
      default: r = '{1'b0, 5'h00, 3'd4, 2'd1, 5'h04};
    endcase
    return r;
  endfunction

  // multiplier is 1, 2 or 3: shift and add
  function automatic logic [33:0] mul_small(input logic [31:0] a, input logic [1:0] m);
    logic [33:0] p;
    case (m)
      2'd2:    p = {1'b0, a, 1'b0};
      2'd3:    p = {2'b00, a} + {1'b0, a, 1'b0};
      default: p = {2'b00, a};
    endcase
    return p;
  endfunction

endpackage

// ===== src/tisc_front.sv =====
// front end: accepts bytes, tracks block boundaries and pushes block events
// depends on tisc_pkg
module tisc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic [31:0]              data_length,
  input  tisc_pkg::q_stat_t        q_stat,
  output logic                     push,
  output tisc_pkg::evt_t           push_evt
);

  tisc_pkg::phase_t            phase, phase_next;
  logic [tisc_pkg::POS_BITS-1:0] pos, pos_next;
  logic [tisc_pkg::POS_BITS-1:0] blk_start, blk_start_next;
  logic [7:0]                  cur_id, cur_id_next;
  logic [4:0]                  hdr_idx, hdr_idx_next;
  logic [31:0]                 acc, acc_next;
  logic [32:0]                 skip, skip_next;
  tisc_pkg::rule_t             rule, rule_next;
  tisc_pkg::rule_t             new_rule;
  logic [4:0]                  k;
  logic [31:0]                 acc_new;
  logic [33:0]                 prod;
  logic [32:0]                 skip_dec;
  logic                        take;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;
  assign new_rule = tisc_pkg::lookup_rule(in_byte);
  assign k        = hdr_idx - rule.off;
  assign acc_new  = acc | ({24'b0, in_byte} << {k[1:0], 3'b000});
  assign prod     = tisc_pkg::mul_small(acc_new, rule.mult);
  assign skip_dec = (skip != '0) ? skip - 33'd1 : skip;

  always_comb begin
    phase_next     = phase;
    pos_next       = (pos != '1) ? pos + 1'b1 : pos;
    blk_start_next = blk_start;
    cur_id_next    = cur_id;
    hdr_idx_next   = hdr_idx;
    acc_next       = acc;
    skip_next      = skip;
    rule_next      = rule;
    push           = 1'b0;
    push_evt       = '{blk_start, cur_id, prod, rule.add, rule.known};
    case (phase)
      tisc_pkg::PH_HDR: begin
        if (hdr_idx >= rule.off) begin
          acc_next = acc_new;
          if (({1'b0, k} + 6'd1) >= {3'b000, rule.width}) begin
            push         = 1'b1;
            hdr_idx_next = '0;
            skip_next    = prod[32:0];
            phase_next   = (prod != '0) ? tisc_pkg::PH_SKIP : tisc_pkg::PH_ID;
          end else begin
            hdr_idx_next = hdr_idx + 5'd1;
          end
        end else begin
          hdr_idx_next = hdr_idx + 5'd1;
        end
      end
      tisc_pkg::PH_SKIP: begin
        skip_next  = skip_dec;
        phase_next = (skip_dec == '0) ? tisc_pkg::PH_ID : tisc_pkg::PH_SKIP;
      end
      default: begin
        phase_next = tisc_pkg::PH_ID;
        if (({1'b0, pos} + (tisc_pkg::POS_BITS+1)'(tisc_pkg::SCAN_MARGIN))
            < (tisc_pkg::POS_BITS+1)'(data_length)) begin
          cur_id_next    = in_byte;
          blk_start_next = pos;
          hdr_idx_next   = '0;
          acc_next       = '0;
          rule_next      = new_rule;
          if (new_rule.width == 3'd0) begin
            push      = 1'b1;
            push_evt  = '{pos, in_byte, 34'd0, new_rule.add, new_rule.known};
            skip_next = '0;
          end else begin
            phase_next = tisc_pkg::PH_HDR;
          end
        end
      end
    endcase
    if (!take) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= tisc_pkg::PH_ID;
      pos     <= '0;
      hdr_idx <= '0;
      skip    <= '0;
    end else if (take) begin
      phase   <= phase_next;
      pos     <= pos_next;
      hdr_idx <= hdr_idx_next;
      skip    <= skip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      blk_start <= blk_start_next;
      cur_id    <= cur_id_next;
      acc       <= acc_next;
      rule      <= rule_next;
    end
  end

endmodule

// ===== src/tisc_queue.sv =====
// short event queue between the front end and the record builder
// depends on tisc_pkg
module tisc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tisc_pkg::evt_t    push_evt,
  input  logic              pop,
  output tisc_pkg::evt_t    pop_evt,
  output tisc_pkg::q_stat_t stat
);

  tisc_pkg::evt_t                 mem [tisc_pkg::Q_DEPTH];
  logic [tisc_pkg::Q_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [tisc_pkg::Q_CNT_BITS-1:0] count;
  logic                           do_pop;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == tisc_pkg::Q_CNT_BITS'(tisc_pkg::Q_DEPTH));
  assign do_pop     = pop && stat.valid;
  assign pop_evt    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/tisc_back.sv =====
// back end: turns block events into records with counters, output register
// depends on tisc_pkg
module tisc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  tisc_pkg::q_stat_t             q_stat,
  input  tisc_pkg::evt_t                q_evt,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tisc_pkg::POS_BITS-1:0] block_offset,
  output logic [7:0]                    block_id,
  output logic [32:0]                   body_length,
  output logic                          recognised,
  output logic [tisc_pkg::CNT_BITS-1:0] block_number,
  output logic [tisc_pkg::CNT_BITS-1:0] unknown_total
);

  logic [tisc_pkg::CNT_BITS-1:0] blk_cnt, blk_cnt_next;
  logic [tisc_pkg::CNT_BITS-1:0] unk_cnt, unk_cnt_next;
  logic [33:0]                   body;

  assign pop          = q_stat.valid && (!out_valid || out_ready);
  assign body         = q_evt.prod + {29'b0, q_evt.add};
  assign blk_cnt_next = (blk_cnt != '1) ? blk_cnt + 1'b1 : blk_cnt;
  assign unk_cnt_next = (q_evt.known || unk_cnt == '1) ? unk_cnt : unk_cnt + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      blk_cnt   <= '0;
      unk_cnt   <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        blk_cnt   <= blk_cnt_next;
        unk_cnt   <= unk_cnt_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      block_offset  <= q_evt.offset;
      block_id      <= q_evt.id;
      body_length   <= body[32:0];
      recognised    <= q_evt.known;
      block_number  <= blk_cnt;
      unknown_total <= unk_cnt_next;
    end
  end

endmodule

// ===== src/tape_image_block_scanner_core.sv =====
// tape image block scanner, top level: config register, front end, queue, back end
// a record reaches the output register after the event of the byte that completes it has passed the event queue
// throughput: one byte per cycle; s_axis_tready falls only while the 4-entry event queue
// is full, which happens when the output side stalls
// reset (rst, synchronous): scan state, counters and queue clear, data_length reads 0
// depends on tisc_pkg, tisc_front, tisc_queue, tisc_back
module tape_image_block_scanner_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // data_byte
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata,   // block_offset, block_id, body_length,
                                        // block_number, unknown_total, zero fill
  output logic [0:0]    m_axis_tuser,   // recognised
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data        // data_length
);

  logic [31:0]                   data_length;
  tisc_pkg::q_stat_t             q_stat;
  tisc_pkg::evt_t                push_evt, pop_evt;
  logic                          push, pop;
  logic [tisc_pkg::POS_BITS-1:0] block_offset;
  logic [7:0]                    block_id;
  logic [32:0]                   body_length;
  logic                          recognised;
  logic [tisc_pkg::CNT_BITS-1:0] block_number, unknown_total;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_length <= '0;
    end else if (cfg_valid) begin
      data_length <= cfg_data;
    end
  end

  tisc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_byte     (s_axis_tdata),
    .data_length (data_length),
    .q_stat      (q_stat),
    .push        (push),
    .push_evt    (push_evt)
  );

  tisc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .pop_evt  (pop_evt),
    .stat     (q_stat)
  );

  tisc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .q_evt         (pop_evt),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .block_offset  (block_offset),
    .block_id      (block_id),
    .body_length   (body_length),
    .recognised    (recognised),
    .block_number  (block_number),
    .unknown_total (unknown_total)
  );

  assign m_axis_tdata = {7'b0, unknown_total, block_number, body_length, block_id,
                         block_offset};
  assign m_axis_tuser = recognised;

endmodule

// ===== src/tisc_checker.sv =====
// port-level checks for the tape image block scanner, bound to the top level
// depends on tape_image_block_scanner_core_defines.svh
`include "tape_image_block_scanner_core_defines.svh"

module tisc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         cfg_valid,
  input logic         cfg_ready
);

  `TISC_ASSERT(out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `TISC_ASSERT(unknown_counted, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[104:89] != '0)
  `TISC_ASSERT_RST(reset_empty, rst |=> !m_axis_tvalid && s_axis_tready)
  `TISC_ASSERT(cfg_always_ready, cfg_valid |-> cfg_ready)

endmodule

bind tape_image_block_scanner_core tisc_checker u_tisc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);
